// ===== rtl/tmac_pkg.sv =====
// ----------------------------------------------------------------------------
// tmac_pkg
// Shared types and constants of the tile memory allocator and compactor.
// ----------------------------------------------------------------------------
package tmac_pkg;

  localparam int TOTAL_CHARS = 2048;
  localparam int MAX_REGIONS = 64;
  localparam int KEY_BITS    = 16;
  localparam int SLOT_W      = 6;
  localparam int OFS_W       = 11;
  localparam int CNT_W       = 7;
  localparam int USERS_W     = 8;
  localparam logic [USERS_W-1:0] USERS_MAX = 8'd255;

  typedef enum logic [1:0] {
    FN_GET     = 2'd0,
    FN_RELEASE = 2'd1,
    FN_DEFRAG  = 2'd2,
    FN_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_SHARED  = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_STILL   = 3'd3,
    ST_FREED   = 3'd4,
    ST_BADH    = 3'd5
  } status_e;

  // One row of the region table
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                shared;
    logic [OFS_W-1:0]    start;
    logic [OFS_W-1:0]    size;
    logic [USERS_W-1:0]  users;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  // Request as taken from the input channel
  typedef struct packed {
    func_e               func;
    logic [KEY_BITS-1:0] key;
    logic                shared;
    logic [OFS_W-1:0]    nchars;
    logic [SLOT_W-1:0]   handle;
    logic                deferred;
  } req_t;

  // Result handed to the output stage
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [OFS_W-1:0]  offset;
    logic [OFS_W-1:0]  used;
    logic [OFS_W:0]    free;
    logic [CNT_W-1:0]  count;
    logic [OFS_W-1:0]  mark;
  } res_t;

endpackage

// ===== rtl/tmac_ram.sv =====
// ----------------------------------------------------------------------------
// tmac_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module tmac_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/tmac_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmac_ctrl
// Request sequencer: walks the order list and region table memories.
// ----------------------------------------------------------------------------
module tmac_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  tmac_pkg::req_t  req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output tmac_pkg::res_t  res_o
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_G_ORD  = 19'h00002,
    S_G_SLT  = 19'h00004,
    S_G_CHK  = 19'h00008,
    S_G_ALOC = 19'h00010,
    S_G_FREE = 19'h00020,
    S_R_SLT  = 19'h00040,
    S_R_CHK  = 19'h00080,
    S_R_FIND = 19'h00100,
    S_R_FCHK = 19'h00200,
    S_R_SHRD = 19'h00400,
    S_R_SHWR = 19'h00800,
    S_D_ORD  = 19'h01000,
    S_D_SLT  = 19'h02000,
    S_D_CHK  = 19'h04000,
    S_E_ORD  = 19'h08000,
    S_E_SLT  = 19'h10000,
    S_E_CHK  = 19'h20000,
    S_DONE   = 19'h40000
  } state_e;

  localparam int SW = tmac_pkg::SLOT_W;
  localparam int OW = tmac_pkg::OFS_W;
  localparam int CW = tmac_pkg::CNT_W;

  state_e state_q, state_d;
  tmac_pkg::req_t req_q, req_d;
  logic [CW-1:0] idx_q, idx_d, live_q, live_d;
  logic [OW-1:0] mark_q, mark_d, end_q, end_d, start_q, start_d, offset_q, offset_d;
  logic [SW-1:0] sidx_q, sidx_d, slot_q, slot_d;
  tmac_pkg::status_e status_q, status_d;
  logic [tmac_pkg::MAX_REGIONS-1:0] valid_q, valid_d;

  logic          ord_we;
  logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic          slt_we;
  logic [SW-1:0] slt_waddr, slt_raddr;
  tmac_pkg::slot_t slt_wdata, slt_rdata;

  logic [OW-1:0] alloc_start;
  logic [OW:0]   alloc_end;
  logic [CW-1:0] idx_inc;

  tmac_ram #(.Width(SW), .Depth(tmac_pkg::MAX_REGIONS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  tmac_ram #(.Width(tmac_pkg::SLOT_BITS), .Depth(tmac_pkg::MAX_REGIONS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slt_we),
    .waddr_i (slt_waddr),
    .wdata_i (slt_wdata),
    .raddr_i (slt_raddr),
    .rdata_o (slt_rdata)
  );

  assign idx_inc     = idx_q + CW'(1);
  assign alloc_start = (live_q == '0) ? OW'(1) : end_q;
  assign alloc_end   = {1'b0, alloc_start} + {1'b0, req_q.nchars};

  // Sequence one request through the memories
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    idx_d     = idx_q;
    live_d    = live_q;
    mark_d    = mark_q;
    end_d     = end_q;
    start_d   = start_q;
    offset_d  = offset_q;
    sidx_d    = sidx_q;
    slot_d    = slot_q;
    status_d  = status_q;
    valid_d   = valid_q;
    ord_we    = 1'b0;
    ord_waddr = idx_q[SW-1:0];
    ord_wdata = '0;
    ord_raddr = idx_q[SW-1:0];
    slt_we    = 1'b0;
    slt_waddr = sidx_q;
    slt_wdata = slt_rdata;
    slt_raddr = sidx_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d    = req_i;
          status_d = tmac_pkg::ST_NEW;
          slot_d   = '0;
          offset_d = '0;
          idx_d    = '0;
          unique case (req_i.func)
            tmac_pkg::FN_GET: begin
              state_d = (req_i.shared && live_q != '0) ? S_G_ORD : S_G_ALOC;
            end
            tmac_pkg::FN_RELEASE: begin
              slot_d = req_i.handle;
              if (!valid_q[req_i.handle]) begin
                status_d = tmac_pkg::ST_BADH;
                state_d  = S_DONE;
              end else begin
                sidx_d  = req_i.handle;
                state_d = S_R_SLT;
              end
            end
            tmac_pkg::FN_DEFRAG: begin
              state_d = (mark_q > OW'(1)) ? S_D_ORD : S_DONE;
            end
            default: begin
              valid_d = '0;
              live_d  = '0;
              mark_d  = OW'(1);
              end_d   = '0;
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Shared lookup: order entry, then region row, then compare
      S_G_ORD: state_d = S_G_SLT;
      S_G_SLT: begin
        sidx_d    = ord_rdata;
        slt_raddr = ord_rdata;
        state_d   = S_G_CHK;
      end
      S_G_CHK: begin
        if (slt_rdata.shared && slt_rdata.key == req_q.key) begin
          if (slt_rdata.users < tmac_pkg::USERS_MAX) begin
            slt_we          = 1'b1;
            slt_wdata.users = slt_rdata.users + 8'd1;
          end
          status_d = tmac_pkg::ST_SHARED;
          slot_d   = sidx_q;
          offset_d = slt_rdata.start;
          state_d  = S_DONE;
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc == live_q) ? S_G_ALOC : S_G_ORD;
        end
      end

      // Bump allocation after the last region
      S_G_ALOC: begin
        if (req_q.nchars == '0 || live_q == CW'(tmac_pkg::MAX_REGIONS) ||
            alloc_end >= (OW+1)'(tmac_pkg::TOTAL_CHARS)) begin
          status_d = tmac_pkg::ST_NOSPACE;
          state_d  = S_DONE;
        end else begin
          start_d = alloc_start;
          idx_d   = '0;
          state_d = S_G_FREE;
        end
      end
      S_G_FREE: begin
        if (!valid_q[idx_q[SW-1:0]]) begin
          slt_we           = 1'b1;
          slt_waddr        = idx_q[SW-1:0];
          slt_wdata.key    = req_q.key;
          slt_wdata.shared = req_q.shared;
          slt_wdata.start  = start_q;
          slt_wdata.size   = req_q.nchars;
          slt_wdata.users  = 8'd1;
          ord_we           = 1'b1;
          ord_waddr        = live_q[SW-1:0];
          ord_wdata        = idx_q[SW-1:0];
          valid_d[idx_q[SW-1:0]] = 1'b1;
          live_d   = live_q + CW'(1);
          end_d    = OW'({1'b0, start_q} + {1'b0, req_q.nchars});
          status_d = tmac_pkg::ST_NEW;
          slot_d   = idx_q[SW-1:0];
          offset_d = start_q;
          state_d  = S_DONE;
        end else begin
          idx_d = idx_inc;
        end
      end

      // Release: drop a user, free the region at zero
      S_R_SLT: state_d = S_R_CHK;
      S_R_CHK: begin
        offset_d = slt_rdata.start;
        if (slt_rdata.users > 8'd1) begin
          slt_we          = 1'b1;
          slt_wdata.users = slt_rdata.users - 8'd1;
          status_d        = tmac_pkg::ST_STILL;
          state_d         = S_DONE;
        end else begin
          valid_d[sidx_q] = 1'b0;
          if (mark_q == OW'(1) || slt_rdata.start < mark_q) begin
            mark_d = slt_rdata.start;
          end
          status_d = tmac_pkg::ST_FREED;
          idx_d    = '0;
          state_d  = S_R_FIND;
        end
      end
      S_R_FIND: state_d = S_R_FCHK;
      S_R_FCHK: begin
        if (ord_rdata == sidx_q) begin
          state_d = S_R_SHRD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_R_FIND;
        end
      end
      // Close the gap in the order list one entry at a time
      S_R_SHRD: begin
        if (idx_inc < live_q) begin
          ord_raddr = idx_inc[SW-1:0];
          state_d   = S_R_SHWR;
        end else begin
          live_d  = live_q - CW'(1);
          state_d = S_E_ORD;
        end
      end
      S_R_SHWR: begin
        ord_we    = 1'b1;
        ord_wdata = ord_rdata;
        idx_d     = idx_inc;
        state_d   = S_R_SHRD;
      end

      // Compaction pass over the regions in order; a deferred request stops after one move
      S_D_ORD: begin
        if (idx_q == live_q) begin
          mark_d  = OW'(1);
          state_d = S_E_ORD;
        end else begin
          state_d = S_D_SLT;
        end
      end
      S_D_SLT: begin
        sidx_d    = ord_rdata;
        slt_raddr = ord_rdata;
        state_d   = S_D_CHK;
      end
      S_D_CHK: begin
        if (mark_q < slt_rdata.start) begin
          slt_we          = 1'b1;
          slt_wdata.start = mark_q;
          mark_d          = OW'({1'b0, mark_q} + {1'b0, slt_rdata.size});
          idx_d           = '0;
          state_d         = req_q.deferred ? S_E_ORD : S_D_ORD;
        end else begin
          if (mark_q == slt_rdata.start) begin
            mark_d = OW'({1'b0, mark_q} + {1'b0, slt_rdata.size});
          end
          idx_d   = idx_inc;
          state_d = S_D_ORD;
        end
      end

      // Recompute the end of the last region
      S_E_ORD: begin
        ord_raddr = SW'(live_q - CW'(1));
        if (live_q == '0) begin
          end_d   = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_E_SLT;
        end
      end
      S_E_SLT: begin
        slt_raddr = ord_rdata;
        state_d   = S_E_CHK;
      end
      S_E_CHK: begin
        end_d   = OW'({1'b0, slt_rdata.start} + {1'b0, slt_rdata.size});
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      live_q  <= '0;
      mark_q  <= OW'(1);
      end_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      mark_q  <= mark_d;
      end_q   <= end_d;
      valid_q <= valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    idx_q    <= idx_d;
    start_q  <= start_d;
    offset_q <= offset_d;
    sidx_q   <= sidx_d;
    slot_q   <= slot_d;
    status_q <= status_d;
  end

  assign req_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.slot   = slot_q;
  assign res_o.offset = offset_q;
  assign res_o.used   = end_q;
  assign res_o.free   = (OW+1)'(tmac_pkg::TOTAL_CHARS) - {1'b0, end_q};
  assign res_o.count  = live_q;
  assign res_o.mark   = mark_q;

endmodule

// ===== rtl/tile_memory_allocator_compactor_unit.sv =====
// ----------------------------------------------------------------------------
// tile_memory_allocator_compactor_unit
// Region allocator for a tile memory with sharing, release and compaction.
// ----------------------------------------------------------------------------
// Channel   Dir  tuser            tdata
// s_axis    in   func [1:0]       spec_key, is_shared, num_chars, handle, deferred
// m_axis    out  status [2:0]     slot_out, region_offset, used_chars, free_chars,
//                                 region_count, freed_mark
//
// One item at a time. Get: for a shared key, scans the live regions in order for a
// match, then searches for a free slot (up to 64 tested). Release: drops a user
// while still used, else finds the region in the order list, shifts later entries
// down and recomputes the end. Defragment: visits regions in order, restarting the
// pass after each move, or stops after one move if deferred. Clear empties the table.
// The order list and region table memories have one read port each. Reset empties
// the table at once; an output register holds a result while the next item is taken.
module tile_memory_allocator_compactor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // func
  input  logic [39:0] s_axis_tdata,   // spec_key, is_shared, num_chars, handle, deferred
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [2:0]  m_axis_tuser,   // status
  output logic [63:0] m_axis_tdata    // slot_out, region_offset, used_chars,
                                      // free_chars, region_count, freed_mark
);

  tmac_pkg::req_t req;
  tmac_pkg::res_t res, res_q;
  logic           res_valid, res_ready, out_valid_q;

  // Unpack the request
  assign req.func     = tmac_pkg::func_e'(s_axis_tuser);
  assign req.key      = s_axis_tdata[15:0];
  assign req.shared   = s_axis_tdata[16];
  assign req.nchars   = s_axis_tdata[27:17];
  assign req.handle   = s_axis_tdata[33:28];
  assign req.deferred = s_axis_tdata[34];

  tmac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {6'd0, res_q.mark, res_q.count, res_q.free,
                          res_q.used, res_q.offset, res_q.slot};

endmodule
